// ===== src/owbm_pkg.sv =====
// shared types, constants and register map of the one-wire bus master
// no dependencies; the top level, owbm_regs and owbm_step import this package
`default_nettype none

package owbm_pkg;

  localparam int unsigned TIME_WIDTH = 11;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned REG_IDX_W  = 3;

  // register reset values
  localparam logic [TIME_WIDTH-1:0] RESET_LOW_TIME_RST     = TIME_WIDTH'(520);
  localparam logic [BYTE_W-1:0]     PRESENCE_INTERVAL_RST  = 8'd5;
  localparam logic [BYTE_W-1:0]     PRESENCE_SAMPLES_RST   = 8'd96;
  localparam logic [BYTE_W-1:0]     PRESENCE_LIMIT_RST     = 8'd83;
  localparam logic [BYTE_W-1:0]     WRITE_ZERO_LOW_RST     = 8'd70;
  localparam logic [BYTE_W-1:0]     WRITE_ONE_LOW_RST      = 8'd10;
  localparam logic [BYTE_W-1:0]     READ_SAMPLE_TIME_RST   = 8'd16;
  localparam logic [BYTE_W-1:0]     SLOT_TIME_RST          = 8'd80;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_RESET = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_READ  = 2'd3
  } owbm_mode_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RST_LOW  = 3'd1,
    PH_PRESENCE = 3'd2,
    PH_WRITE    = 3'd3,
    PH_READ     = 3'd4
  } owbm_phase_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_RESET_LOW_TIME    = 3'd0,
    REG_PRESENCE_INTERVAL = 3'd1,
    REG_PRESENCE_SAMPLES  = 3'd2,
    REG_PRESENCE_LIMIT    = 3'd3,
    REG_WRITE_ZERO_LOW    = 3'd4,
    REG_WRITE_ONE_LOW     = 3'd5,
    REG_READ_SAMPLE_TIME  = 3'd6,
    REG_SLOT_TIME         = 3'd7
  } owbm_reg_e;

  typedef struct packed {
    logic [TIME_WIDTH-1:0] reset_low_time;
    logic [BYTE_W-1:0]     presence_interval;
    logic [BYTE_W-1:0]     presence_samples;
    logic [BYTE_W-1:0]     presence_limit;
    logic [BYTE_W-1:0]     write_zero_low_time;
    logic [BYTE_W-1:0]     write_one_low_time;
    logic [BYTE_W-1:0]     read_sample_time;
    logic [BYTE_W-1:0]     slot_time;
  } owbm_cfg_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [BYTE_W-1:0] write_value;
    logic              line_level;
  } owbm_item_t;

  typedef struct packed {
    logic              drive_low;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] presence_count;
    logic              device_present;
    logic [BYTE_W-1:0] read_value;
  } owbm_res_t;

endpackage

`default_nettype wire

// ===== src/owbm_cmd_if.sv =====
// command / tick channel of the one-wire bus master
// valid-ready handshake; payload widths follow owbm_pkg
`default_nettype none

interface owbm_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] write_value;
  logic       line_level;

  modport source (output valid, mode, write_value, line_level, input ready);
  modport sink   (input valid, mode, write_value, line_level, output ready);
endinterface

`default_nettype wire

// ===== src/owbm_res_if.sv =====
// result channel of the one-wire bus master
// valid-ready handshake; payload widths follow owbm_pkg
`default_nettype none

interface owbm_res_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] presence_count;
  logic       device_present;
  logic [7:0] read_value;

  modport source (output valid, drive_low, busy_res, done_res, presence_count,
                  device_present, read_value, input ready);
  modport sink   (input valid, drive_low, busy_res, done_res, presence_count,
                  device_present, read_value, output ready);
endinterface

`default_nettype wire

// ===== src/one_wire_bus_master_unit.sv =====
// top level of the one-wire bus master: handshakes, result register, apb port
// depends on owbm_pkg, owbm_cmd_if, owbm_res_if, owbm_regs and owbm_step
//
//   channel   dir   handshake          payload
//   cmd_i     in    valid / ready      mode, write_value, line_level
//   res_o     out   valid / ready      drive_low, busy_res, done_res,
//                                      presence_count, device_present, read_value
//   apb       in    psel / penable     paddr, pwdata, prdata (pready tied high)
//
// one transaction per cycle while cmd ready is high: each accepted tick or command updates the
// sequencer state and loads the result register at the same edge
// the result register sits between the two sides; cmd ready is low only while
// a result waits and the sink holds ready low
// reset is asynchronous and active low; no clearing pass is needed after it
// configuration writes are taken at any time, one register per apb access
`default_nettype none

module one_wire_bus_master_unit import owbm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  owbm_cmd_if.sink              cmd_i,
  owbm_res_if.source            res_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  owbm_cfg_t  cfg;
  owbm_item_t item;
  owbm_res_t  res_d, res_q;
  logic       res_valid_q;
  logic       cmd_accept;

  // configuration registers
  owbm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // take a new transaction whenever the result slot is free or being drained
  assign cmd_i.ready = !res_valid_q || res_o.ready;
  assign cmd_accept  = cmd_i.valid && cmd_i.ready;

  assign item.mode        = cmd_i.mode;
  assign item.write_value = cmd_i.write_value;
  assign item.line_level  = cmd_i.line_level;

  // phase, timing counters and shift byte
  owbm_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (cmd_accept),
    .item_i (item),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_accept) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_accept) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.drive_low      = res_q.drive_low;
  assign res_o.busy_res       = res_q.busy_res;
  assign res_o.done_res       = res_q.done_res;
  assign res_o.presence_count = res_q.presence_count;
  assign res_o.device_present = res_q.device_present;
  assign res_o.read_value     = res_q.read_value;

  // a stalled result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_accept |-> !(res_valid_q && !res_o.ready))
    else $error("transaction accepted over a stalled result");

  // every accepted transaction shows up as a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_accept |=> res_o.valid)
    else $error("result missing after accepted transaction");

  // the finishing item releases the bus and ends the operation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.done_res |-> !res_o.busy_res && !res_o.drive_low)
    else $error("done result still busy or driving");

  // the bus is only pulled low while an operation runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.drive_low |-> res_o.busy_res)
    else $error("bus driven low while idle");

endmodule

`default_nettype wire

// ===== src/owbm_regs.sv =====
// apb-style configuration register file of the one-wire bus master
// depends on owbm_pkg
`default_nettype none

module owbm_regs import owbm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output owbm_cfg_t             cfg_o
);

  owbm_cfg_t cfg_q, cfg_d;
  owbm_reg_e reg_sel;
  logic      wr_en;

  assign pready  = 1'b1;
  assign reg_sel = owbm_reg_e'(paddr[APB_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_RESET_LOW_TIME:    cfg_d.reset_low_time      = pwdata[TIME_WIDTH-1:0];
        REG_PRESENCE_INTERVAL: cfg_d.presence_interval   = pwdata[BYTE_W-1:0];
        REG_PRESENCE_SAMPLES:  cfg_d.presence_samples    = pwdata[BYTE_W-1:0];
        REG_PRESENCE_LIMIT:    cfg_d.presence_limit      = pwdata[BYTE_W-1:0];
        REG_WRITE_ZERO_LOW:    cfg_d.write_zero_low_time = pwdata[BYTE_W-1:0];
        REG_WRITE_ONE_LOW:     cfg_d.write_one_low_time  = pwdata[BYTE_W-1:0];
        REG_READ_SAMPLE_TIME:  cfg_d.read_sample_time    = pwdata[BYTE_W-1:0];
        REG_SLOT_TIME:         cfg_d.slot_time           = pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_RESET_LOW_TIME:    prdata = APB_DATA_W'(cfg_q.reset_low_time);
      REG_PRESENCE_INTERVAL: prdata = APB_DATA_W'(cfg_q.presence_interval);
      REG_PRESENCE_SAMPLES:  prdata = APB_DATA_W'(cfg_q.presence_samples);
      REG_PRESENCE_LIMIT:    prdata = APB_DATA_W'(cfg_q.presence_limit);
      REG_WRITE_ZERO_LOW:    prdata = APB_DATA_W'(cfg_q.write_zero_low_time);
      REG_WRITE_ONE_LOW:     prdata = APB_DATA_W'(cfg_q.write_one_low_time);
      REG_READ_SAMPLE_TIME:  prdata = APB_DATA_W'(cfg_q.read_sample_time);
      REG_SLOT_TIME:         prdata = APB_DATA_W'(cfg_q.slot_time);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_time      <= RESET_LOW_TIME_RST;
      cfg_q.presence_interval   <= PRESENCE_INTERVAL_RST;
      cfg_q.presence_samples    <= PRESENCE_SAMPLES_RST;
      cfg_q.presence_limit      <= PRESENCE_LIMIT_RST;
      cfg_q.write_zero_low_time <= WRITE_ZERO_LOW_RST;
      cfg_q.write_one_low_time  <= WRITE_ONE_LOW_RST;
      cfg_q.read_sample_time    <= READ_SAMPLE_TIME_RST;
      cfg_q.slot_time           <= SLOT_TIME_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== src/owbm_step.sv =====
// bus sequencer of the one-wire bus master: phase, slot timing and sampling
// depends on owbm_pkg; state advances once per accepted transaction
`default_nettype none

module owbm_step import owbm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  owbm_item_t item_i,
  input  owbm_cfg_t  cfg_i,
  output owbm_res_t  res_o
);

  owbm_phase_e           phase_q, phase_d;
  logic [TIME_WIDTH-1:0] tick_q, tick_d, tick_inc;
  logic [2:0]            bit_q, bit_d;
  logic [BYTE_W-1:0]     shift_q, shift_d;
  logic [BYTE_W-1:0]     sample_q, sample_d;
  logic [BYTE_W-1:0]     high_q, high_d;
  logic                  present_q, present_d;
  logic [BYTE_W-1:0]     last_read_q, last_read_d;
  logic [BYTE_W-1:0]     slot_eff, ivl_eff, rd_pt, low_pt;
  logic                  drive, done, writing;

  // low times and sample point stay inside 1 .. slot-1
  function automatic logic [BYTE_W-1:0] clamp_slot(input logic [BYTE_W-1:0] v,
                                                   input logic [BYTE_W-1:0] s);
    logic [BYTE_W-1:0] top;
    top = s - 8'd1;
    if (v == '0) begin
      return 8'd1;
    end else if (v > top) begin
      return top;
    end else begin
      return v;
    end
  endfunction

  assign slot_eff = (cfg_i.slot_time < 8'd2) ? 8'd2 : cfg_i.slot_time;
  assign ivl_eff  = (cfg_i.presence_interval == '0) ? 8'd1 : cfg_i.presence_interval;
  assign rd_pt    = clamp_slot(cfg_i.read_sample_time, slot_eff);
  assign tick_inc = tick_q + TIME_WIDTH'(1);
  assign writing  = (phase_q == PH_WRITE);

  always_comb begin
    phase_d     = phase_q;
    tick_d      = tick_q;
    bit_d       = bit_q;
    shift_d     = shift_q;
    sample_d    = sample_q;
    high_d      = high_q;
    present_d   = present_q;
    last_read_d = last_read_q;
    drive       = 1'b0;
    done        = 1'b0;
    low_pt      = '0;
    case (phase_q)
      PH_IDLE: begin
        if (owbm_mode_e'(item_i.mode) != MODE_TICK) begin
          tick_d = '0;
          bit_d  = '0;
          drive  = 1'b1;
          case (owbm_mode_e'(item_i.mode))
            MODE_RESET: begin
              phase_d  = PH_RST_LOW;
              high_d   = '0;
              sample_d = '0;
            end
            MODE_WRITE: begin
              phase_d = PH_WRITE;
              shift_d = item_i.write_value;
            end
            default: begin
              phase_d = PH_READ;
              shift_d = '0;
            end
          endcase
        end
      end
      PH_RST_LOW: begin
        if (tick_inc >= cfg_i.reset_low_time) begin
          phase_d = PH_PRESENCE;
          tick_d  = '0;
        end else begin
          tick_d = tick_inc;
          drive  = 1'b1;
        end
      end
      PH_PRESENCE: begin
        if (tick_inc >= TIME_WIDTH'(ivl_eff)) begin
          tick_d = '0;
          if (item_i.line_level && high_q != 8'hFF) begin
            high_d = high_q + 8'd1;
          end
          sample_d = sample_q + 8'd1;
          if (sample_d >= cfg_i.presence_samples) begin
            present_d = (high_d <= cfg_i.presence_limit);
            phase_d   = PH_IDLE;
            done      = 1'b1;
          end
        end else begin
          tick_d = tick_inc;
        end
      end
      PH_WRITE, PH_READ: begin
        tick_d = tick_inc;
        if (!writing && tick_inc == TIME_WIDTH'(rd_pt)) begin
          shift_d[bit_q] = shift_q[bit_q] | item_i.line_level;
        end
        if (tick_inc >= TIME_WIDTH'(slot_eff)) begin
          tick_d = '0;
          if (bit_q == 3'd7) begin
            if (!writing) begin
              last_read_d = shift_d;
            end
            phase_d = PH_IDLE;
            bit_d   = '0;
            done    = 1'b1;
          end else begin
            bit_d = bit_q + 3'd1;
            if (writing) begin
              shift_d = shift_d >> 1;
            end
          end
        end
        low_pt = clamp_slot(shift_d[0] ? cfg_i.write_one_low_time
                                       : cfg_i.write_zero_low_time, slot_eff);
        if (!done) begin
          drive = writing ? (tick_d < TIME_WIDTH'(low_pt)) : (tick_d == '0);
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      sample_q    <= '0;
      high_q      <= '0;
      present_q   <= 1'b0;
      last_read_q <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      tick_q      <= tick_d;
      bit_q       <= bit_d;
      shift_q     <= shift_d;
      sample_q    <= sample_d;
      high_q      <= high_d;
      present_q   <= present_d;
      last_read_q <= last_read_d;
    end
  end

  assign res_o.drive_low      = drive;
  assign res_o.busy_res       = (phase_d != PH_IDLE);
  assign res_o.done_res       = done;
  assign res_o.presence_count = high_d;
  assign res_o.device_present = present_d;
  assign res_o.read_value     = last_read_d;

endmodule

`default_nettype wire
